>>> sv/ppp_pkg.sv
// shared widths, register map and reset values for the pinhole point projector
package ppp_pkg;

    // field widths
    localparam int ROT_W     = 18;
    localparam int ROW_W     = 3 * ROT_W;
    localparam int PT_W      = 24;
    localparam int TRANS_W   = 24;
    localparam int FOCAL_W   = 20;
    localparam int PIX_W     = 15;
    localparam int CENTER_W  = 2 * PIX_W;

    // configuration port
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 6;
    localparam int REG_IDX_W = 3;

    // datapath widths
    localparam int PROD_W    = ROT_W + PT_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_DROP = 8;
    localparam int CAM_W     = ACC_W - FRAC_DROP;
    localparam int FX_W      = FOCAL_W + 1 + CAM_W;
    localparam int DIV_W     = FX_W;
    localparam int DIV_BITS  = 16;
    localparam int COORD_W   = DIV_BITS + 3;
    localparam int LATENCY   = 6 + DIV_BITS;

    // default image size in pixels
    localparam int IMG_WIDTH_DEF  = 1024;
    localparam int IMG_HEIGHT_DEF = 1024;

    // reset values form the identity transform
    localparam logic [ROW_W-1:0]    ROT0_RST   = ROW_W'(64'd65536);
    localparam logic [ROW_W-1:0]    ROT1_RST   = ROW_W'(64'd17179869184);
    localparam logic [ROW_W-1:0]    ROT2_RST   = ROW_W'(64'd4503599627370496);
    localparam logic [FOCAL_W-1:0]  FOCAL_RST  = FOCAL_W'(256);
    localparam logic [CENTER_W-1:0] CENTER_RST = '0;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROT0,
        REG_ROT1,
        REG_ROT2,
        REG_TX,
        REG_TY,
        REG_TZ,
        REG_FOCAL,
        REG_CENTER
    } t_reg_idx;

endpackage

>>> sv/pinhole_point_projector.sv
// pinhole point projector: rigid transform, perspective divide and viewport clip
//
//  channel   | signals                                    | direction | transaction when
//  ----------+--------------------------------------------+-----------+--------------------------
//  point in  | start, busy, i_world_x/y/z                 | in        | start && !busy
//  pixel out | o_strobe, o_pixel_col, o_pixel_row         | out       | o_strobe (one cycle)
//  config    | psel, penable, pwrite, paddr, pwdata,      | in/out    | psel && penable && pwrite
//            | prdata, pready                             |           |   (register at 8*index)
//
// one point enters per clock; each pixel passes through the 16-stage restoring
// divider, which produces one quotient bit per stage
// busy is high only while reset is asserted; reset is synchronous and clears the
// valid bits and the configuration registers
// points that land on or outside the image border, or have zero depth, drop out
// of the pipeline without a strobe; nothing ever holds the pipeline
module pinhole_point_projector #(
    parameter int IMG_WIDTH  = ppp_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = ppp_pkg::IMG_HEIGHT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // point channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [ppp_pkg::PT_W-1:0]       i_world_x,
    input  logic signed [ppp_pkg::PT_W-1:0]       i_world_y,
    input  logic signed [ppp_pkg::PT_W-1:0]       i_world_z,
    // pixel channel
    output logic                                  o_strobe,
    output logic        [ppp_pkg::PIX_W-1:0]      o_pixel_col,
    output logic        [ppp_pkg::PIX_W-1:0]      o_pixel_row,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic        [ppp_pkg::APB_AW-1:0]     paddr,
    input  logic        [ppp_pkg::APB_DW-1:0]     pwdata,
    output logic        [ppp_pkg::APB_DW-1:0]     prdata,
    output logic                                  pready
);
    import ppp_pkg::*;

    // clip limits in Q11.4
    localparam logic signed [COORD_W-1:0] COL_LIM = COORD_W'(IMG_WIDTH * 16);
    localparam logic signed [COORD_W-1:0] ROW_LIM = COORD_W'(IMG_HEIGHT * 16);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic        [ROW_W-1:0]    r_rot   [3];
    logic signed [TRANS_W-1:0]  r_trans [3];
    logic        [FOCAL_W-1:0]  r_focal;
    logic        [CENTER_W-1:0] r_center;
    logic                       cfg_wr;
    t_reg_idx                   cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:APB_AW-REG_IDX_W]);
    assign pready  = 1'b1;
    assign busy    = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= ROT0_RST;
            r_rot[1]   <= ROT1_RST;
            r_rot[2]   <= ROT2_RST;
            r_trans[0] <= '0;
            r_trans[1] <= '0;
            r_trans[2] <= '0;
            r_focal    <= FOCAL_RST;
            r_center   <= CENTER_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROT0:   r_rot[0]   <= pwdata[ROW_W-1:0];
                REG_ROT1:   r_rot[1]   <= pwdata[ROW_W-1:0];
                REG_ROT2:   r_rot[2]   <= pwdata[ROW_W-1:0];
                REG_TX:     r_trans[0] <= pwdata[TRANS_W-1:0];
                REG_TY:     r_trans[1] <= pwdata[TRANS_W-1:0];
                REG_TZ:     r_trans[2] <= pwdata[TRANS_W-1:0];
                REG_FOCAL:  r_focal    <= pwdata[FOCAL_W-1:0];
                REG_CENTER: r_center   <= pwdata[CENTER_W-1:0];
            endcase
        end
    end

    // register readback, zero extended
    always_comb begin
        unique case (cfg_idx)
            REG_ROT0:   prdata = APB_DW'(r_rot[0]);
            REG_ROT1:   prdata = APB_DW'(r_rot[1]);
            REG_ROT2:   prdata = APB_DW'(r_rot[2]);
            REG_TX:     prdata = APB_DW'(unsigned'(r_trans[0]));
            REG_TY:     prdata = APB_DW'(unsigned'(r_trans[1]));
            REG_TZ:     prdata = APB_DW'(unsigned'(r_trans[2]));
            REG_FOCAL:  prdata = APB_DW'(r_focal);
            REG_CENTER: prdata = APB_DW'(r_center);
        endcase
    end

    // ------------------------------------------------------------------
    // stage 1: nine rotation products, Q2.16 x Q16.8 exact at 2^-24
    // ------------------------------------------------------------------
    logic                      accept;
    logic signed [PT_W-1:0]    pt [3];
    logic                      r_s1_vld;
    logic signed [PROD_W-1:0]  r_s1_prod [3][3];

    assign accept = start && !busy;
    assign pt[0]  = i_world_x;
    assign pt[1]  = i_world_y;
    assign pt[2]  = i_world_z;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_s1_prod[i][j] <= $signed(r_rot[i][ROT_W*j +: ROT_W]) * pt[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: dot products plus translation, floored to 2^-16
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc [3];
    logic                    r_s2_vld;
    logic signed [CAM_W-1:0] r_s2_cam [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = (ACC_W'(r_trans[i]) <<< 16)
                   + ACC_W'(r_s1_prod[i][0])
                   + ACC_W'(r_s1_prod[i][1])
                   + ACC_W'(r_s1_prod[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s2_cam[i] <= acc[i][ACC_W-1:FRAC_DROP];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: focal scaling of x and y
    // ------------------------------------------------------------------
    logic signed [FOCAL_W:0]  focal_s;
    logic                     r_s3_vld;
    logic signed [FX_W-1:0]   r_s3_fx;
    logic signed [FX_W-1:0]   r_s3_fy;
    logic signed [CAM_W-1:0]  r_s3_w;

    assign focal_s = $signed({1'b0, r_focal});

    always_ff @(posedge i_clk) begin
        r_s3_fx <= FX_W'(focal_s) * FX_W'(r_s2_cam[0]);
        r_s3_fy <= FX_W'(focal_s) * FX_W'(r_s2_cam[1]);
        r_s3_w  <= r_s2_cam[2];
    end

    // ------------------------------------------------------------------
    // stage 4: magnitudes and quotient signs; divisor is 16 * |w|
    // ------------------------------------------------------------------
    logic               r_s4_vld;
    logic [DIV_W-1:0]   r_s4_nc;
    logic [DIV_W-1:0]   r_s4_nr;
    logic [DIV_W-1:0]   r_s4_den;
    logic               r_s4_neg_c;
    logic               r_s4_neg_r;
    logic               r_s4_zero;
    logic [CAM_W-1:0]   w_abs;

    assign w_abs = r_s3_w[CAM_W-1] ? CAM_W'(-r_s3_w) : CAM_W'(r_s3_w);

    always_ff @(posedge i_clk) begin
        r_s4_nc    <= r_s3_fx[FX_W-1] ? DIV_W'(-r_s3_fx) : DIV_W'(r_s3_fx);
        r_s4_nr    <= r_s3_fy[FX_W-1] ? DIV_W'(-r_s3_fy) : DIV_W'(r_s3_fy);
        r_s4_den   <= DIV_W'(w_abs) << 4;
        r_s4_neg_c <= r_s3_fx[FX_W-1] ^ r_s3_w[CAM_W-1];
        r_s4_neg_r <= r_s3_fy[FX_W-1] ^ r_s3_w[CAM_W-1];
        r_s4_zero  <= (r_s3_w == '0);
    end

    // ------------------------------------------------------------------
    // stage 5 and divider: a quotient of 2^16 or more always lands outside
    // the image, so it is flagged and only 16 quotient bits are formed
    // ------------------------------------------------------------------
    logic                  r_div_vld   [DIV_BITS+1];
    logic                  r_div_drop  [DIV_BITS+1];
    logic                  r_div_neg_c [DIV_BITS+1];
    logic                  r_div_neg_r [DIV_BITS+1];
    logic [DIV_W-1:0]      r_div_den   [DIV_BITS+1];
    logic [DIV_W-1:0]      r_div_rem_c [DIV_BITS+1];
    logic [DIV_W-1:0]      r_div_rem_r [DIV_BITS+1];
    logic [DIV_BITS-1:0]   r_div_q_c   [DIV_BITS+1];
    logic [DIV_BITS-1:0]   r_div_q_r   [DIV_BITS+1];
    logic [DIV_W-1:0]      den_top;

    assign den_top = r_s4_den << DIV_BITS;

    always_ff @(posedge i_clk) begin
        r_div_drop[0]  <= r_s4_zero || (r_s4_nc >= den_top) || (r_s4_nr >= den_top);
        r_div_neg_c[0] <= r_s4_neg_c;
        r_div_neg_r[0] <= r_s4_neg_r;
        r_div_den[0]   <= r_s4_den;
        r_div_rem_c[0] <= r_s4_nc;
        r_div_rem_r[0] <= r_s4_nr;
        r_div_q_c[0]   <= '0;
        r_div_q_r[0]   <= '0;
    end

    for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
        localparam int B = DIV_BITS - k;
        logic [DIV_W:0] n_trial_c;
        logic [DIV_W:0] n_trial_r;
        logic [DIV_W-1:0] den_sh;

        // one restoring step per stage for each lane
        assign den_sh    = r_div_den[k-1] << B;
        assign n_trial_c = {1'b0, r_div_rem_c[k-1]} - {1'b0, den_sh};
        assign n_trial_r = {1'b0, r_div_rem_r[k-1]} - {1'b0, den_sh};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_vld[k] <= 1'b0;
            end else begin
                r_div_vld[k] <= r_div_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_div_drop[k]  <= r_div_drop[k-1];
            r_div_neg_c[k] <= r_div_neg_c[k-1];
            r_div_neg_r[k] <= r_div_neg_r[k-1];
            r_div_den[k]   <= r_div_den[k-1];
            r_div_rem_c[k] <= n_trial_c[DIV_W] ? r_div_rem_c[k-1] : n_trial_c[DIV_W-1:0];
            r_div_rem_r[k] <= n_trial_r[DIV_W] ? r_div_rem_r[k-1] : n_trial_r[DIV_W-1:0];
            r_div_q_c[k]   <= {r_div_q_c[k-1][DIV_BITS-2:0], ~n_trial_c[DIV_W]};
            r_div_q_r[k]   <= {r_div_q_r[k-1][DIV_BITS-2:0], ~n_trial_r[DIV_W]};
        end
    end

    // ------------------------------------------------------------------
    // output stage: signed quotient plus image center, strict clip
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] q_c;
    logic signed [COORD_W-1:0] q_r;
    logic signed [COORD_W-1:0] n_col;
    logic signed [COORD_W-1:0] n_row;
    logic                      n_hit;
    logic                      r_out_vld;
    logic [PIX_W-1:0]          r_out_col;
    logic [PIX_W-1:0]          r_out_row;

    always_comb begin
        q_c   = $signed(COORD_W'(r_div_q_c[DIV_BITS]));
        q_r   = $signed(COORD_W'(r_div_q_r[DIV_BITS]));
        n_col = (r_div_neg_c[DIV_BITS] ? -q_c : q_c)
              + $signed(COORD_W'(r_center[PIX_W-1:0]));
        n_row = (r_div_neg_r[DIV_BITS] ? -q_r : q_r)
              + $signed(COORD_W'(r_center[CENTER_W-1:PIX_W]));
        n_hit = !r_div_drop[DIV_BITS]
              && (n_col > 0) && (n_col < COL_LIM)
              && (n_row > 0) && (n_row < ROW_LIM);
    end

    always_ff @(posedge i_clk) begin
        r_out_col <= n_col[PIX_W-1:0];
        r_out_row <= n_row[PIX_W-1:0];
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_s3_vld     <= 1'b0;
            r_s4_vld     <= 1'b0;
            r_div_vld[0] <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_s1_vld     <= accept;
            r_s2_vld     <= r_s1_vld;
            r_s3_vld     <= r_s2_vld;
            r_s4_vld     <= r_s3_vld;
            r_div_vld[0] <= r_s4_vld;
            r_out_vld    <= r_div_vld[DIV_BITS] && n_hit;
        end
    end

    assign o_strobe    = r_out_vld;
    assign o_pixel_col = r_out_col;
    assign o_pixel_row = r_out_row;

endmodule

>>> sv/ppp_checker.sv
// port-level checks for the pinhole point projector, bound to the top level
module ppp_checker #(
    parameter int IMG_WIDTH  = ppp_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = ppp_pkg::IMG_HEIGHT_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic [ppp_pkg::PIX_W-1:0]     o_pixel_col,
    input logic [ppp_pkg::PIX_W-1:0]     o_pixel_row,
    input logic                          pready
);
    import ppp_pkg::*;

    localparam logic [PIX_W-1:0] COL_LIM = PIX_W'(IMG_WIDTH * 16);
    localparam logic [PIX_W-1:0] ROW_LIM = PIX_W'(IMG_HEIGHT * 16);

    // every pixel comes from a point accepted a fixed latency earlier
    a_strobe_has_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("pixel without a matching point transaction");

    // emitted pixels lie strictly inside the image
    a_pixel_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_pixel_col != '0) && (o_pixel_row != '0)
                  && (o_pixel_col < COL_LIM) && (o_pixel_row < ROW_LIM))
        else $error("pixel on or outside the image border");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("pixel strobe right after reset");

    // config port never inserts wait states
    a_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind pinhole_point_projector ppp_checker #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
) u_ppp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_pixel_col (o_pixel_col),
    .o_pixel_row (o_pixel_row),
    .pready      (pready)
);

>>> tb/pinhole_point_projector_tb.sv
// testbench for the pinhole point projector: directed points, random phases, pixel checks
module pinhole_point_projector_tb;
    import ppp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [PT_W-1:0] PT_MAX = 24'sh7FFFFF;
    localparam logic signed [PT_W-1:0] PT_MIN = 24'sh800000;

    typedef struct packed {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
    } t_pixel;

    // hit and drop rows carry a typed expectation, pred rows go through the predictor
    typedef enum logic [1:0] {STEP_HIT, STEP_DROP, STEP_PRED, STEP_CONFIG} t_step_kind;

    typedef enum logic [1:0] {
        CFG_IDENTITY_LIKE,
        CFG_ALL_HIGH,
        CFG_ALL_LOW,
        CFG_NOISE
    } t_cfg_style;

    typedef struct {
        t_step_kind              kind;
        t_reg_idx                reg_idx;
        logic [APB_DW-1:0]       value;
        logic signed [PT_W-1:0]  x;
        logic signed [PT_W-1:0]  y;
        logic signed [PT_W-1:0]  z;
        t_pixel                  want;
    } t_step;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic signed [PT_W-1:0]     i_world_x;
    logic signed [PT_W-1:0]     i_world_y;
    logic signed [PT_W-1:0]     i_world_z;
    logic                       o_strobe;
    logic [PIX_W-1:0]           o_pixel_col;
    logic [PIX_W-1:0]           o_pixel_row;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    // shadow copy of the camera registers
    logic [ROW_W-1:0]           rot_q [3];
    logic signed [TRANS_W-1:0]  trans_q [3];
    logic [FOCAL_W-1:0]         focal_q;
    logic [CENTER_W-1:0]        center_q;

    t_pixel pending_pixels [$];
    int     mismatches = 0;
    int     cycle_count = 0;
    int     burst_left = 0;

    pinhole_point_projector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_world_x   (i_world_x),
        .i_world_y   (i_world_y),
        .i_world_z   (i_world_z),
        .o_strobe    (o_strobe),
        .o_pixel_col (o_pixel_col),
        .o_pixel_row (o_pixel_row),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // rotate, translate, divide by depth, clip; returns 1 when a pixel comes out
    function automatic bit project_point(input logic signed [PT_W-1:0] px, py, pz,
                                         output t_pixel pix);
        longint pt [3];
        longint cam [3];
        longint acc, den, col, row;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        pix = '0;
        for (int r = 0; r < 3; r++) begin
            acc = longint'(trans_q[r]) * 65536;
            for (int j = 0; j < 3; j++) begin
                acc += longint'($signed(rot_q[r][ROT_W*j +: ROT_W])) * pt[j];
            end
            cam[r] = acc >>> FRAC_DROP;
        end
        // a non-negative depth below one step of the camera grid drops the point
        if (cam[2] == 0) return 1'b0;
        den = cam[2] * 16;
        col = (longint'(focal_q) * cam[0]) / den + longint'(center_q[PIX_W-1:0]);
        row = (longint'(focal_q) * cam[1]) / den + longint'(center_q[CENTER_W-1:PIX_W]);
        // the border itself is outside
        if (col <= 0 || col >= IMG_WIDTH_DEF * 16) return 1'b0;
        if (row <= 0 || row >= IMG_HEIGHT_DEF * 16) return 1'b0;
        pix.col = col[PIX_W-1:0];
        pix.row = row[PIX_W-1:0];
        return 1'b1;
    endfunction

    // setup then access phase; shadow copy follows the register at the write edge
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(8 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_ROT0:   rot_q[0]   = value[ROW_W-1:0];
            REG_ROT1:   rot_q[1]   = value[ROW_W-1:0];
            REG_ROT2:   rot_q[2]   = value[ROW_W-1:0];
            REG_TX:     trans_q[0] = value[TRANS_W-1:0];
            REG_TY:     trans_q[1] = value[TRANS_W-1:0];
            REG_TZ:     trans_q[2] = value[TRANS_W-1:0];
            REG_FOCAL:  focal_q    = value[FOCAL_W-1:0];
            REG_CENTER: center_q   = value[CENTER_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one point transaction, with a random gap ahead of each burst
    task automatic send_point(input logic signed [PT_W-1:0] x, y, z,
                              input t_step_kind kind, input t_pixel want);
        int     gap;
        t_pixel pix;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                start     <= 1'b0;
                i_world_x <= PT_W'($urandom);
                i_world_y <= PT_W'($urandom);
                i_world_z <= PT_W'($urandom);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_world_x <= x;
        i_world_y <= y;
        i_world_z <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (kind)
            STEP_HIT:  pending_pixels = {pending_pixels, want};
            STEP_PRED: if (project_point(x, y, z, pix)) pending_pixels = {pending_pixels, pix};
            default: ;
        endcase
        burst_left--;
    endtask

    // dropped points leave no trace, so let the whole pipeline empty out
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg_style style);
        logic [APB_DW-1:0] vals [8];
        logic [ROW_W-1:0]  packed_row;
        int                e;
        case (style)
            CFG_ALL_HIGH: begin
                for (int r = 0; r < 3; r++) vals[r] = 64'h003F_FFFF_FFFF_FFFF;
                for (int r = 3; r < 6; r++) vals[r] = 64'h7F_FFFF;
                vals[REG_FOCAL]  = 64'hF_FFFF;
                vals[REG_CENTER] = 64'h3FFF_FFFF;
            end
            CFG_ALL_LOW: begin
                // zero focal length pins every pixel to the center
                for (int r = 0; r < 3; r++) vals[r] = '0;
                for (int r = 3; r < 6; r++) vals[r] = 64'h80_0000;
                vals[REG_FOCAL]  = '0;
                vals[REG_CENTER] = 64'({15'd8000, 15'd8000});
            end
            CFG_NOISE: begin
                // full 64-bit values, the bits above each register are dropped
                for (int r = 0; r < 8; r++) vals[r] = {$urandom, $urandom};
            end
            default: begin
                // identity with small skew, short translation, center near the middle
                for (int r = 0; r < 3; r++) begin
                    packed_row = '0;
                    for (int j = 0; j < 3; j++) begin
                        e = ((r == j) ? 65536 : 0) + int'($urandom_range(0, 4095)) - 2048;
                        packed_row[ROT_W*j +: ROT_W] = e[ROT_W-1:0];
                    end
                    vals[r] = 64'(packed_row);
                end
                for (int r = 3; r < 6; r++) vals[r] = 64'(int'($urandom_range(0, 8191)) - 4096);
                vals[REG_FOCAL]  = 64'($urandom_range(64, 65535));
                vals[REG_CENTER] = 64'({15'($urandom_range(2048, 14336)),
                                        15'($urandom_range(2048, 14336))});
            end
        endcase
        for (int i = 0; i < 8; i++) apb_write(t_reg_idx'(i), vals[i]);
    endtask

    // mostly points aimed into the frustum for the current focal length, some noise
    task automatic run_phase(input int n_points);
        longint                 depth, span, f;
        logic signed [PT_W-1:0] px, py, pz;
        for (int i = 0; i < n_points; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                px = PT_W'($urandom);
                py = PT_W'($urandom);
                pz = PT_W'($urandom);
            end else begin
                f     = (focal_q == 0) ? 1 : longint'(focal_q);
                depth = $urandom_range(256, 1 << 20);
                span  = 6000 * 16 * depth / f;
                if (span > 8388607) span = 8388607;
                px = PT_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
                py = PT_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
                pz = PT_W'(depth);
                // mirror the point through the origin to put it behind the camera; it is still projected
                if ($urandom_range(0, 7) == 0) begin
                    px = -px;
                    py = -py;
                    pz = -pz;
                end
            end
            send_point(px, py, pz, STEP_PRED, '0);
        end
    endtask

    // result side: strobe is a one-cycle transaction, compared against the oldest entry
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel col %0d row %0d", $time,
                         o_pixel_col, o_pixel_row);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_col !== want.col) begin
                    $display("%0t: pixel_col expected %0d got %0d", $time,
                             want.col, o_pixel_col);
                    mismatches++;
                end
                if (o_pixel_row !== want.row) begin
                    $display("%0t: pixel_row expected %0d got %0d", $time,
                             want.row, o_pixel_row);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_step      point_script [29];
        t_cfg_style style;
        int         n_points;

        // reset config is identity, unit focal length, center at zero:
        // col = 16 * x / z and row = 16 * y / z in Q.4
        point_script = '{
            '{STEP_HIT,  REG_ROT0, 64'd0, 24'sd256, 24'sd256, 24'sd256, {15'd16, 15'd16}},
            '{STEP_HIT,  REG_ROT0, 64'd0, 24'sd512, 24'sd768, 24'sd256, {15'd32, 15'd48}},
            '{STEP_HIT,  REG_ROT0, 64'd0, 24'sd1280, 24'sd768, 24'sd512, {15'd40, 15'd24}},
            // quotient truncates
            '{STEP_HIT,  REG_ROT0, 64'd0, 24'sd256, 24'sd256, 24'sd768, {15'd5, 15'd5}},
            // on the left and top borders
            '{STEP_DROP, REG_ROT0, 64'd0, 24'sd0, 24'sd256, 24'sd256, '0},
            '{STEP_DROP, REG_ROT0, 64'd0, 24'sd256, 24'sd0, 24'sd256, '0},
            // last pixel inside, then on the right and bottom borders
            '{STEP_HIT,  REG_ROT0, 64'd0, 24'sd261888, 24'sd261888, 24'sd256,
              {15'd16368, 15'd16368}},
            '{STEP_DROP, REG_ROT0, 64'd0, 24'sd262144, 24'sd256, 24'sd256, '0},
            '{STEP_DROP, REG_ROT0, 64'd0, 24'sd256, 24'sd262144, 24'sd256, '0},
            // zero depth
            '{STEP_DROP, REG_ROT0, 64'd0, 24'sd256, 24'sd256, 24'sd0, '0},
            // behind the camera, projected anyway
            '{STEP_HIT,  REG_ROT0, 64'd0, -24'sd256, -24'sd256, -24'sd256, {15'd16, 15'd16}},
            '{STEP_HIT,  REG_ROT0, 64'd0, -24'sd1, -24'sd1, -24'sd1, {15'd16, 15'd16}},
            '{STEP_HIT,  REG_ROT0, 64'd0, PT_MAX, PT_MAX, PT_MAX, {15'd16, 15'd16}},
            '{STEP_HIT,  REG_ROT0, 64'd0, PT_MIN, PT_MIN, PT_MIN, {15'd16, 15'd16}},
            '{STEP_DROP, REG_ROT0, 64'd0, PT_MAX, PT_MAX, 24'sd1, '0},
            '{STEP_DROP, REG_ROT0, 64'd0, 24'sd1, 24'sd1, PT_MAX, '0},
            '{STEP_DROP, REG_ROT0, 64'd0, 24'sd256, 24'sd512, -24'sd256, '0},
            // principal point at (100, 200)
            '{STEP_CONFIG, REG_CENTER, 64'd6553700, '0, '0, '0, '0},
            '{STEP_HIT,  REG_ROT0, 64'd0, 24'sd256, 24'sd256, 24'sd256, {15'd116, 15'd216}},
            // depth row of a single lsb: tiny positive depth drops, tiny negative does not
            '{STEP_CONFIG, REG_ROT2, 64'h0000_0010_0000_0000, '0, '0, '0, '0},
            '{STEP_DROP, REG_ROT0, 64'd0, 24'sd0, 24'sd0, 24'sd255, '0},
            '{STEP_HIT,  REG_ROT0, 64'd0, 24'sd0, 24'sd0, -24'sd1, {15'd100, 15'd200}},
            // translation, widest focal length
            '{STEP_CONFIG, REG_ROT2, 64'(ROT2_RST), '0, '0, '0, '0},
            '{STEP_CONFIG, REG_TX, 64'hFFFF_FFFF_FFFF_FF00, '0, '0, '0, '0},
            '{STEP_CONFIG, REG_TZ, 64'd256, '0, '0, '0, '0},
            '{STEP_CONFIG, REG_FOCAL, 64'hF_FFFF, '0, '0, '0, '0},
            '{STEP_PRED, REG_ROT0, 64'd0, 24'sd256, 24'sd256, 24'sd0, '0},
            '{STEP_PRED, REG_ROT0, 64'd0, PT_MIN, PT_MAX, PT_MAX, '0},
            '{STEP_PRED, REG_ROT0, 64'd0, 24'sd100, -24'sd300, 24'sd5000, '0}
        };

        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_world_x = '0;
        i_world_y = '0;
        i_world_z = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        rot_q[0]  = ROT0_RST;
        rot_q[1]  = ROT1_RST;
        rot_q[2]  = ROT2_RST;
        trans_q[0] = '0;
        trans_q[1] = '0;
        trans_q[2] = '0;
        focal_q   = FOCAL_RST;
        center_q  = CENTER_RST;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (point_script[k]) begin
            if (point_script[k].kind == STEP_CONFIG) begin
                wait_idle();
                apb_write(point_script[k].reg_idx, point_script[k].value);
            end else begin
                send_point(point_script[k].x, point_script[k].y, point_script[k].z,
                           point_script[k].kind, point_script[k].want);
            end
        end

        // register extremes first, then full-noise settings, then many camera poses
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:       style = CFG_ALL_HIGH;
                1:       style = CFG_ALL_LOW;
                2, 3:    style = CFG_NOISE;
                default: style = CFG_IDENTITY_LIKE;
            endcase
            n_points = (ph < 2) ? 40 : (ph < 4) ? 60 : 106;
            wait_idle();
            load_config(style);
            run_phase(n_points);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
